>>> sv/qmr_pkg.sv
// Shared types and constants for the quaternion multiply / rotate unit.
// Used by qmr_pass and quaternion_multiply_rotate; no dependencies.
package qmr_pkg;

  localparam int COMP_BITS       = 32;
  localparam int NUM_COMP        = 4;
  localparam int PROD_BITS       = 2 * COMP_BITS;
  localparam int STAGES_PER_PASS = 3;

  // Component order in a quaternion: index 0 = w, 1 = x, 2 = y, 3 = z.
  typedef logic [COMP_BITS-1:0]   comp_t;
  typedef comp_t [NUM_COMP-1:0]   quat_t;
  typedef logic [1:0]             comp_idx_t;

  typedef enum logic {
    KIND_PRODUCT = 1'b0,
    KIND_ROTATE  = 1'b1
  } kind_t;

  // Hamilton product sign table: result component k sums p[i] * q[i ^ k],
  // and bit i of HAM_NEG[k] marks a term that is subtracted.
  localparam logic [NUM_COMP-1:0][NUM_COMP-1:0] HAM_NEG = '{
    4'b0100,
    4'b0010,
    4'b1000,
    4'b1110
  };

  // Load enables of the three registers of one Hamilton pass.
  typedef struct packed {
    logic mul;
    logic add;
    logic fin;
  } pass_en_t;

endpackage

>>> sv/qmr_pass.sv
// One pipelined fixed-point Hamilton product p * q (or p * conj(q)) in three stages.
// Depends on qmr_pkg; instantiated twice by quaternion_multiply_rotate.
module qmr_pass #(
  parameter int FRAC_BITS  = 24,
  parameter int COMP_WIDTH = 32
) (
  input  logic              clk,
  input  qmr_pkg::pass_en_t en,
  input  qmr_pkg::quat_t    p,
  input  qmr_pkg::quat_t    q,
  input  logic              conj,
  output qmr_pkg::quat_t    r
);
  import qmr_pkg::*;

  localparam int SAT_W  = (COMP_WIDTH < COMP_BITS) ? COMP_WIDTH : COMP_BITS;
  localparam int PAIR_W = PROD_BITS + 1;
  localparam int SUM_W  = PROD_BITS + 3;

  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W-SAT_W+1){1'b1}}, {(SAT_W-1){1'b0}}};

  logic signed [PROD_BITS-1:0]        prod [NUM_COMP][NUM_COMP];
  logic [NUM_COMP-1:0][NUM_COMP-1:0]  neg;
  logic signed [PAIR_W-1:0]           pair [NUM_COMP][2];
  logic signed [SUM_W-1:0]            total [NUM_COMP];
  logic signed [SUM_W-1:0]            scaled [NUM_COMP];

  function automatic logic signed [PAIR_W-1:0] signed_term(
    input logic signed [PROD_BITS-1:0] v,
    input logic                        n
  );
    logic signed [PAIR_W-1:0] ext;
    ext = PAIR_W'(v);
    return n ? -ext : ext;
  endfunction

  // Stage 1: sixteen raw products and their signs.
  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        for (int i = 0; i < NUM_COMP; i++) begin
          prod[k][i] <= $signed(p[comp_idx_t'(i)]) * $signed(q[comp_idx_t'(i ^ k)]);
          neg[k][i]  <= HAM_NEG[k][i] ^ (conj && (i != k));
        end
      end
    end
  end

  // Stage 2: apply signs, add in pairs.
  always_ff @(posedge clk) begin
    if (en.add) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        for (int h = 0; h < 2; h++) begin
          pair[k][h] <= signed_term(prod[k][2*h], neg[k][2*h])
                      + signed_term(prod[k][2*h+1], neg[k][2*h+1]);
        end
      end
    end
  end

  // Stage 3: final sum, round half up, saturate.
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      total[k]  = SUM_W'(pair[k][0]) + SUM_W'(pair[k][1]) + HALF;
      scaled[k] = total[k] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en.fin) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        priority if (scaled[k] > SAT_MAX) begin
          r[k] <= SAT_MAX[COMP_BITS-1:0];
        end else if (scaled[k] < SAT_MIN) begin
          r[k] <= SAT_MIN[COMP_BITS-1:0];
        end else begin
          r[k] <= scaled[k][COMP_BITS-1:0];
        end
      end
    end
  end

endmodule

>>> sv/quaternion_multiply_rotate.sv
// Top level of the quaternion multiply / rotate unit: handshake, stage control, two passes.
// Depends on qmr_pkg and qmr_pass.
//
// Fixed-point quaternion unit with FRAC_BITS fraction bits. kind = 0 returns the
// Hamilton product a*b; kind = 1 rotates the vector (b_x, b_y, b_z) by a as
// a*v*conj(a), with b_w ignored and the inner product rounded and saturated
// before the second product. Each result component is the exact sum of four
// products, rounded to nearest (ties toward plus infinity) and saturated to
// min(COMP_WIDTH, 32) signed bits, sign-extended onto the 32-bit port. The unit
// takes one beat per cycle while op_stall is low and returns each result after
// two Hamilton passes of three stages each (multiply, pair add, final add with
// round and saturate). A product beat runs through the second pass too, times
// the unit quaternion, which leaves it unchanged. Every stage has its own valid
// bit and moves whenever the stage after it is empty or moving, so bubbles
// close up and new beats are taken while a finished result waits on res_stall;
// op_stall rises only when all six stages hold a beat and the output is stalled.
module quaternion_multiply_rotate #(
  parameter int FRAC_BITS  = 24,
  parameter int COMP_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 op_valid,
  output logic                                 op_stall,
  input  logic                                 kind,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] a_w,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] a_x,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] a_y,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] a_z,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] b_w,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] b_x,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] b_y,
  input  logic signed [qmr_pkg::COMP_BITS-1:0] b_z,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic signed [qmr_pkg::COMP_BITS-1:0] r_w,
  output logic signed [qmr_pkg::COMP_BITS-1:0] r_x,
  output logic signed [qmr_pkg::COMP_BITS-1:0] r_y,
  output logic signed [qmr_pkg::COMP_BITS-1:0] r_z
);
  import qmr_pkg::*;

  localparam int    NUM_STAGES = 2 * STAGES_PER_PASS;
  localparam comp_t ONE_FIX    = comp_t'(1) << FRAC_BITS;
  localparam quat_t UNIT       = {{((NUM_COMP-1)*COMP_BITS){1'b0}}, ONE_FIX};

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_in;
  logic [NUM_STAGES:0]   adv;

  kind_t side_kind [STAGES_PER_PASS];
  quat_t side_a    [STAGES_PER_PASS];

  kind_t    op_kind;
  quat_t    op_a;
  quat_t    op_b;
  quat_t    mid;
  quat_t    pass2_q;
  logic     pass2_conj;
  quat_t    res;
  pass_en_t en1;
  pass_en_t en2;

  // Stage control: a stage may load when it is empty or its contents move on.
  always_comb begin
    adv[NUM_STAGES] = !res_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign vld_in    = {vld[NUM_STAGES-2:0], op_valid};
  assign op_stall  = !adv[0];
  assign res_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign en1 = '{mul: adv[0], add: adv[1], fin: adv[2]};
  assign en2 = '{mul: adv[3], add: adv[4], fin: adv[5]};

  // First pass: a * b, with the scalar of b dropped for a rotation.
  assign op_kind = kind_t'(kind);
  assign op_a    = {a_z, a_y, a_x, a_w};
  assign op_b    = {b_z, b_y, b_x, (op_kind == KIND_ROTATE) ? comp_t'(0) : comp_t'(b_w)};

  // Carry kind and a alongside the first pass for use by the second.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_kind[0] <= op_kind;
      side_a[0]    <= op_a;
    end
    for (int s = 1; s < STAGES_PER_PASS; s++) begin
      if (adv[s]) begin
        side_kind[s] <= side_kind[s-1];
        side_a[s]    <= side_a[s-1];
      end
    end
  end

  qmr_pass #(
    .FRAC_BITS  (FRAC_BITS),
    .COMP_WIDTH (COMP_WIDTH)
  ) u_pass1 (
    .clk  (clk),
    .en   (en1),
    .p    (op_a),
    .q    (op_b),
    .conj (1'b0),
    .r    (mid)
  );

  // Second pass: rotate by conj(a), or pass the product through times one.
  assign pass2_conj = (side_kind[STAGES_PER_PASS-1] == KIND_ROTATE);
  assign pass2_q    = pass2_conj ? side_a[STAGES_PER_PASS-1] : UNIT;

  qmr_pass #(
    .FRAC_BITS  (FRAC_BITS),
    .COMP_WIDTH (COMP_WIDTH)
  ) u_pass2 (
    .clk  (clk),
    .en   (en2),
    .p    (mid),
    .q    (pass2_q),
    .conj (pass2_conj),
    .r    (res)
  );

  assign r_w = res[0];
  assign r_x = res[1];
  assign r_y = res[2];
  assign r_z = res[3];

  // Input is held off only with every stage full and the output stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> (&vld && res_stall))
    else $error("op_stall raised with a free stage");

  // A taken beat lands in the first stage.
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> vld[0])
    else $error("accepted beat missing from first stage");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule
